>>> rtl/far_pkg.sv
// Shared types and constants for the frame allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package far_pkg;

    localparam int FRAME_COUNT = 1024;
    localparam int OWNER_COUNT = 64;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int LINK_W      = FRAME_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(FRAME_COUNT);

    localparam int W_FIRST = 10;
    localparam int W_OWNER = 6;
    localparam int W_PAGE  = 20;
    localparam int W_RUN   = 11;
    localparam int W_AGE   = 8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_REF   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EVICT = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    localparam logic [1:0] KIND_PAGE = 2'd0;

    localparam logic [W_AGE-1:0] AGE_FRESH = 8'd0;
    localparam logic [W_AGE-1:0] AGE_REUSE = 8'd128;
    localparam logic [W_AGE:0]   AGE_NONE  = 9'd256;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [W_RUN-1:0]   run_length;
        logic [1:0]         frame_kind;
        logic [W_OWNER-1:0] owner_id;
        logic [W_PAGE-1:0]  virt_page;
        logic [9:0]         target_frame;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_status;
        logic [W_FIRST-1:0] first_frame;
        logic [W_OWNER-1:0] evicted_owner;
        logic [W_PAGE-1:0]  evicted_page;
    } t_out_item;

    // per-frame state word
    typedef struct packed {
        logic             mapped;
        logic             queued;
        logic             refd;
        logic [W_AGE-1:0] age;
    } t_meta;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_MAP_A,
        OP_MAP_B,
        OP_AGE_RD,
        OP_AGE_UPD,
        OP_EV_RD,
        OP_EV_LAT,
        OP_UL_A,
        OP_UL_B,
        OP_TGT_RD,
        OP_TGT_CHK,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic [1:0] req_type;
        logic       args_ok;
        logic       target_ok;
        logic       found;
        logic       idx_last;
        logic       q_empty;
        logic       mode;
        logic       nx_nil;
        logic       free_unlink;
        logic       k_last;
        logic       out_free;
    } t_status;

endpackage

>>> rtl/frame_allocator_fifo_aging.sv
// Frame allocator with FIFO or aging replacement; top level.
// Depends on far_pkg, far_ctrl, far_dp (and far_ram through far_dp).
//
// One request word at a time. After reset the block clears every entry of its
// frame table before taking the first word. An allocate scans the table frame
// by frame and maps each frame of the run it finds; with no free run and a
// non-empty queue, the victim is the queue head (FIFO) or the lowest-aged
// queued frame (aging search), and it is evicted and unlinked, then remapped.
// Free and mark-referenced update the target frame; freeing a queued frame also
// unlinks it. The frame tables share a single read port.
// A finished result waits in an output register while the next word is taken.
module frame_allocator_fifo_aging import far_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    t_op     s_op;
    t_status s_st;

    far_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (s_st),
        .o_op       (s_op),
        .o_in_stall (o_in_stall)
    );

    far_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_op),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_st        (s_st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/far_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module far_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/far_ctrl.sv
// Sequencer for the frame allocator: steps the datapath through each request.
// Depends on far_pkg.
module far_ctrl import far_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_st,
    output t_op     o_op,
    output logic    o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MAP_A,
        S_MAP_B,
        S_AGE_RD,
        S_AGE_UPD,
        S_EV_RD,
        S_EV_LAT,
        S_UL_A,
        S_UL_B,
        S_TGT_RD,
        S_TGT_CHK,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_st.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_st.req_type)
                    REQ_ALLOC: n_state = i_st.args_ok ? S_SCAN_RD : S_FINISH;
                    REQ_FREE,
                    REQ_REF:   n_state = i_st.target_ok ? S_TGT_RD : S_FINISH;
                    default:   n_state = S_FINISH;
                endcase
            end
            S_SCAN_RD: begin
                o_op    = OP_SCAN_RD;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_op = OP_SCAN_CHK;
                if (i_st.found) begin
                    n_state = S_MAP_A;
                end else if (!i_st.idx_last) begin
                    n_state = S_SCAN_RD;
                end else if (i_st.q_empty) begin
                    n_state = S_FINISH;
                end else if (i_st.mode) begin
                    n_state = S_AGE_RD;
                end else begin
                    n_state = S_EV_RD;
                end
            end
            S_AGE_RD: begin
                o_op    = OP_AGE_RD;
                n_state = S_AGE_UPD;
            end
            S_AGE_UPD: begin
                o_op    = OP_AGE_UPD;
                n_state = i_st.nx_nil ? S_EV_RD : S_AGE_RD;
            end
            S_EV_RD: begin
                o_op    = OP_EV_RD;
                n_state = S_EV_LAT;
            end
            S_EV_LAT: begin
                o_op    = OP_EV_LAT;
                n_state = S_UL_A;
            end
            S_UL_A: begin
                o_op    = OP_UL_A;
                n_state = S_UL_B;
            end
            S_UL_B: begin
                o_op    = OP_UL_B;
                n_state = (i_st.req_type == REQ_ALLOC) ? S_MAP_A : S_FINISH;
            end
            S_MAP_A: begin
                o_op    = OP_MAP_A;
                n_state = S_MAP_B;
            end
            S_MAP_B: begin
                o_op    = OP_MAP_B;
                n_state = i_st.k_last ? S_FINISH : S_MAP_A;
            end
            S_TGT_RD: begin
                o_op    = OP_TGT_RD;
                n_state = S_TGT_CHK;
            end
            S_TGT_CHK: begin
                o_op    = OP_TGT_CHK;
                n_state = i_st.free_unlink ? S_UL_A : S_FINISH;
            end
            S_FINISH: begin
                o_op = OP_FINISH;
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/far_dp.sv
// Datapath of the frame allocator: frame tables, queue links and result word.
// Depends on far_pkg and far_ram.
module far_dp import far_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_out_stall,
    output t_status   o_st,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    t_in_item              r_req;
    logic                  r_mode;
    logic [FRAME_W-1:0]    r_idx;
    logic [W_RUN-1:0]      r_run;
    logic [FRAME_W-1:0]    r_start;
    logic [FRAME_W-1:0]    r_k;
    logic [FRAME_W-1:0]    r_last;
    logic [LINK_W-1:0]     r_head;
    logic [LINK_W-1:0]     r_tail;
    logic [LINK_W-1:0]     r_cur;
    logic [LINK_W-1:0]     r_best;
    logic [W_AGE:0]        r_best_age;
    logic [LINK_W-1:0]     r_nx;
    logic [LINK_W-1:0]     r_pv;
    logic [W_AGE-1:0]      r_age_new;
    logic [1:0]            r_status;
    logic [W_FIRST-1:0]    r_first;
    logic [W_OWNER-1:0]    r_ev_owner;
    logic [W_PAGE-1:0]     r_ev_page;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [FRAME_W-1:0]        s_raddr;
    logic [FRAME_W-1:0]        s_target;
    t_meta                     s_meta_rd;
    t_meta                     s_meta_wd;
    logic [$bits(t_meta)-1:0]  s_meta_rv;
    logic                      s_meta_we;
    logic [FRAME_W-1:0]        s_meta_wa;
    logic [LINK_W-1:0]         s_nxt_rd;
    logic [LINK_W-1:0]         s_nxt_wd;
    logic                      s_nxt_we;
    logic [FRAME_W-1:0]        s_nxt_wa;
    logic [LINK_W-1:0]         s_prv_rd;
    logic [LINK_W-1:0]         s_prv_wd;
    logic                      s_prv_we;
    logic [FRAME_W-1:0]        s_prv_wa;
    logic [W_OWNER+W_PAGE-1:0] s_info_rd;
    logic                      s_info_we;
    logic                      s_page_kind;
    logic [FRAME_W-1:0]        s_start_nxt;
    logic                      s_found;
    logic [W_AGE-1:0]          s_age_upd;
    logic                      s_out_free;
    logic                      s_is_last;

    assign s_target    = FRAME_W'(r_req.target_frame);
    assign s_meta_rd   = t_meta'(s_meta_rv);
    assign s_page_kind = (r_req.frame_kind == KIND_PAGE);
    assign s_start_nxt = (r_run == '0) ? r_idx : r_start;
    assign s_found     = !s_meta_rd.mapped && ((r_run + W_RUN'(1)) == r_req.run_length);
    assign s_age_upd   = {s_meta_rd.refd, s_meta_rd.age[W_AGE-1:1]};
    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign s_is_last   = (r_idx == FRAME_W'(FRAME_COUNT - 1));

    // shared read address for all tables
    always_comb begin
        case (i_op)
            OP_AGE_RD: s_raddr = r_cur[FRAME_W-1:0];
            OP_EV_RD:  s_raddr = r_best[FRAME_W-1:0];
            OP_TGT_RD: s_raddr = s_target;
            default:   s_raddr = r_idx;
        endcase
    end

    always_comb begin
        s_meta_we = 1'b0;
        s_meta_wa = r_idx;
        s_meta_wd = '0;
        s_nxt_we  = 1'b0;
        s_nxt_wa  = r_k;
        s_nxt_wd  = NIL_LINK;
        s_prv_we  = 1'b0;
        s_prv_wa  = r_k;
        s_prv_wd  = r_tail;
        s_info_we = 1'b0;
        case (i_op)
            OP_CLEAR: begin
                s_meta_we = 1'b1;
            end
            OP_AGE_UPD: begin
                s_meta_we = 1'b1;
                s_meta_wa = r_cur[FRAME_W-1:0];
                s_meta_wd = '{mapped: s_meta_rd.mapped, queued: s_meta_rd.queued,
                              refd: 1'b0, age: s_age_upd};
            end
            OP_MAP_A: begin
                s_meta_we = 1'b1;
                s_meta_wa = r_k;
                s_meta_wd = '{mapped: 1'b1, queued: s_page_kind, refd: 1'b0,
                              age: r_age_new};
                s_info_we = 1'b1;
                s_nxt_we  = s_page_kind;
                s_prv_we  = s_page_kind;
            end
            OP_MAP_B: begin
                s_nxt_we = s_page_kind && (r_tail != NIL_LINK);
                s_nxt_wa = r_tail[FRAME_W-1:0];
                s_nxt_wd = {1'b0, r_k};
            end
            OP_UL_A: begin
                s_nxt_we = (r_pv != NIL_LINK);
                s_nxt_wa = r_pv[FRAME_W-1:0];
                s_nxt_wd = r_nx;
            end
            OP_UL_B: begin
                s_prv_we = (r_nx != NIL_LINK);
                s_prv_wa = r_nx[FRAME_W-1:0];
                s_prv_wd = r_pv;
            end
            OP_TGT_CHK: begin
                s_meta_wa = s_target;
                if (r_req.req_type == REQ_FREE) begin
                    s_meta_we = s_meta_rd.mapped;
                    s_meta_wd = '{mapped: 1'b0, queued: 1'b0, refd: s_meta_rd.refd,
                                  age: s_meta_rd.age};
                end else begin
                    s_meta_we = 1'b1;
                    s_meta_wd = '{mapped: s_meta_rd.mapped, queued: s_meta_rd.queued,
                                  refd: 1'b1, age: s_meta_rd.age};
                end
            end
            default: ;
        endcase
    end

    far_ram #(.WIDTH($bits(t_meta)), .DEPTH(FRAME_COUNT)) u_meta (
        .i_clk   (i_clk),
        .i_we    (s_meta_we),
        .i_waddr (s_meta_wa),
        .i_wdata (s_meta_wd),
        .i_raddr (s_raddr),
        .o_rdata (s_meta_rv)
    );

    far_ram #(.WIDTH(W_OWNER + W_PAGE), .DEPTH(FRAME_COUNT)) u_info (
        .i_clk   (i_clk),
        .i_we    (s_info_we),
        .i_waddr (r_k),
        .i_wdata ({r_req.owner_id, r_req.virt_page}),
        .i_raddr (s_raddr),
        .o_rdata (s_info_rd)
    );

    far_ram #(.WIDTH(LINK_W), .DEPTH(FRAME_COUNT)) u_nxt (
        .i_clk   (i_clk),
        .i_we    (s_nxt_we),
        .i_waddr (s_nxt_wa),
        .i_wdata (s_nxt_wd),
        .i_raddr (s_raddr),
        .o_rdata (s_nxt_rd)
    );

    far_ram #(.WIDTH(LINK_W), .DEPTH(FRAME_COUNT)) u_prv (
        .i_clk   (i_clk),
        .i_we    (s_prv_we),
        .i_waddr (s_prv_wa),
        .i_wdata (s_prv_wd),
        .i_raddr (s_raddr),
        .o_rdata (s_prv_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_idx       <= '0;
            r_head      <= NIL_LINK;
            r_tail      <= NIL_LINK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (i_op == OP_FINISH && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_CLEAR:    r_idx <= r_idx + FRAME_W'(1);
                OP_ACCEPT:   r_idx <= '0;
                OP_SCAN_CHK: r_idx <= r_idx + FRAME_W'(1);
                OP_MAP_B: begin
                    if (s_page_kind) begin
                        if (r_tail == NIL_LINK) r_head <= {1'b0, r_k};
                        r_tail <= {1'b0, r_k};
                    end
                end
                OP_UL_A: begin
                    if (r_pv == NIL_LINK) r_head <= r_nx;
                end
                OP_UL_B: begin
                    if (r_nx == NIL_LINK) r_tail <= r_pv;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_op == OP_FINISH && s_out_free) begin
            r_out <= '{result_status: r_status, first_frame: r_first,
                       evicted_owner: r_ev_owner, evicted_page: r_ev_page};
        end
        case (i_op)
            OP_ACCEPT: begin
                r_req      <= i_in_data;
                r_run      <= '0;
                r_status   <= ST_FAIL;
                r_first    <= '0;
                r_ev_owner <= '0;
                r_ev_page  <= '0;
            end
            OP_SCAN_CHK: begin
                if (s_meta_rd.mapped) begin
                    r_run <= '0;
                end else begin
                    r_run <= r_run + W_RUN'(1);
                end
                r_start <= s_start_nxt;
                if (s_found) begin
                    r_k       <= s_start_nxt;
                    r_last    <= r_idx;
                    r_age_new <= AGE_FRESH;
                    r_status  <= ST_OK;
                    r_first   <= W_FIRST'(s_start_nxt);
                end
                // set up the victim search
                r_cur      <= r_head;
                r_best     <= r_head;
                r_best_age <= AGE_NONE;
            end
            OP_AGE_UPD: begin
                if ({1'b0, s_age_upd} < r_best_age) begin
                    r_best_age <= {1'b0, s_age_upd};
                    r_best     <= r_cur;
                end
                r_cur <= s_nxt_rd;
            end
            OP_EV_LAT: begin
                r_nx       <= s_nxt_rd;
                r_pv       <= s_prv_rd;
                r_ev_owner <= s_info_rd[W_OWNER+W_PAGE-1:W_PAGE];
                r_ev_page  <= s_info_rd[W_PAGE-1:0];
                r_status   <= ST_EVICT;
                r_first    <= W_FIRST'(r_best[FRAME_W-1:0]);
                r_k        <= r_best[FRAME_W-1:0];
                r_last     <= r_best[FRAME_W-1:0];
                r_age_new  <= AGE_REUSE;
            end
            OP_MAP_B: begin
                r_k <= r_k + FRAME_W'(1);
            end
            OP_TGT_CHK: begin
                r_nx     <= s_nxt_rd;
                r_pv     <= s_prv_rd;
                r_status <= ST_OK;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_st             = '0;
        o_st.req_type    = r_req.req_type;
        o_st.args_ok     = (r_req.run_length != '0) && (int'(r_req.owner_id) < OWNER_COUNT);
        o_st.target_ok   = (int'(r_req.target_frame) < FRAME_COUNT);
        o_st.found       = s_found;
        o_st.idx_last    = s_is_last;
        o_st.q_empty     = (r_head == NIL_LINK);
        o_st.mode        = r_mode;
        o_st.nx_nil      = (s_nxt_rd == NIL_LINK);
        o_st.free_unlink = (r_req.req_type == REQ_FREE) && s_meta_rd.mapped
                           && s_meta_rd.queued;
        o_st.k_last      = (r_k == r_last);
        o_st.out_free    = s_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/tb.sv
// Testbench for frame_allocator_fifo_aging: directed table, then random request words.
// Needs far_pkg and the allocator RTL; results are checked against an in-bench table model or a listed result.
`timescale 1ns / 100ps

module tb import far_pkg::*; ();

    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam int NIL = FRAME_COUNT;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      out_stall;
    logic      cfg_we;
    logic      cfg_wdata;

    frame_allocator_fifo_aging uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // frame table model
    bit                 ft_mode;
    bit                 ft_mapped [FRAME_COUNT];
    bit                 ft_refd   [FRAME_COUNT];
    bit                 ft_queued [FRAME_COUNT];
    logic [W_OWNER-1:0] ft_owner  [FRAME_COUNT];
    logic [W_PAGE-1:0]  ft_page   [FRAME_COUNT];
    logic [W_AGE-1:0]   ft_age    [FRAME_COUNT];
    int                 ft_link   [FRAME_COUNT];
    int                 ft_head;
    int                 ft_tail;

    t_out_item pending_results[$];
    int  errors;
    int  words_sent;
    int  evictions;
    int  failures;
    int  idle_pct;
    int  stall_pct;
    bit  checking;

    function automatic void queue_append(int f);
        ft_link[f] = NIL;
        if (ft_head == NIL) ft_head = f;
        else ft_link[ft_tail] = f;
        ft_tail = f;
        ft_queued[f] = 1'b1;
    endfunction

    function automatic void queue_unlink(int f);
        int prev;
        int cur;
        prev = NIL;
        cur = ft_head;
        if (!ft_queued[f]) return;
        for (int s = 0; s < FRAME_COUNT && cur != NIL; s++) begin
            if (cur == f) begin
                if (prev == NIL) ft_head = ft_link[f];
                else ft_link[prev] = ft_link[f];
                if (ft_tail == f) ft_tail = prev;
                break;
            end
            prev = cur;
            cur = ft_link[cur];
        end
        ft_queued[f] = 1'b0;
    endfunction

    function automatic void map_frame(int f, t_in_item w, logic [W_AGE-1:0] age);
        ft_mapped[f] = 1'b1;
        ft_owner[f] = w.owner_id;
        ft_page[f] = w.virt_page;
        ft_age[f] = age;
        ft_refd[f] = 1'b0;
        if (w.frame_kind == KIND_PAGE) queue_append(f);
    endfunction

    function automatic t_out_item predict_word(t_in_item w);
        t_out_item r;
        int len;
        int start;
        int run;
        int victim;
        int cur;
        int a;
        int best_age;
        bit found;
        r = '0;
        r.result_status = ST_FAIL;
        len = int'(w.run_length);
        start = 0;
        run = 0;
        found = 1'b0;
        case (w.req_type)
            REQ_ALLOC: begin
                if (len != 0 && w.owner_id < OWNER_COUNT) begin
                    for (int i = 0; i < FRAME_COUNT; i++) begin
                        if (ft_mapped[i]) begin
                            run = 0;
                            continue;
                        end
                        if (run == 0) start = i;
                        run++;
                        if (run == len) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) begin
                        for (int k = start; k < start + len; k++) map_frame(k, w, AGE_FRESH);
                        r.result_status = ST_OK;
                        r.first_frame = W_FIRST'(start);
                    end else if (ft_head != NIL) begin
                        victim = ft_head;
                        if (ft_mode) begin
                            // age every queued frame, keep the first with the lowest age
                            victim = NIL;
                            best_age = int'(AGE_NONE);
                            cur = ft_head;
                            for (int s = 0; s < FRAME_COUNT && cur != NIL; s++) begin
                                a = int'(ft_age[cur]) >> 1;
                                if (ft_refd[cur]) a += 128;
                                ft_refd[cur] = 1'b0;
                                ft_age[cur] = W_AGE'(a);
                                if (a < best_age) begin
                                    best_age = a;
                                    victim = cur;
                                end
                                cur = ft_link[cur];
                            end
                        end
                        if (victim < FRAME_COUNT) begin
                            r.evicted_owner = ft_owner[victim];
                            r.evicted_page = ft_page[victim];
                            queue_unlink(victim);
                            map_frame(victim, w, AGE_REUSE);
                            r.result_status = ST_EVICT;
                            r.first_frame = W_FIRST'(victim);
                        end
                    end
                end
            end
            REQ_FREE: begin
                if (w.target_frame < FRAME_COUNT) begin
                    if (ft_mapped[w.target_frame]) begin
                        ft_mapped[w.target_frame] = 1'b0;
                        queue_unlink(int'(w.target_frame));
                    end
                    r.result_status = ST_OK;
                end
            end
            REQ_REF: begin
                if (w.target_frame < FRAME_COUNT) begin
                    ft_refd[w.target_frame] = 1'b1;
                    r.result_status = ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(t_in_item w, bit typed, t_out_item typed_res);
        t_out_item p;
        in_data <= w;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_word(w);
        pending_results.push_back(typed ? typed_res : p);
        words_sent++;
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        ft_mode = m;
    endtask

    function automatic t_in_item random_word();
        t_in_item w;
        int pick;
        w = '0;
        w.owner_id = W_OWNER'($urandom_range(OWNER_COUNT - 1));
        w.virt_page = W_PAGE'($urandom);
        w.target_frame = 10'($urandom_range(FRAME_COUNT - 1));
        w.frame_kind = ($urandom_range(99) < 70) ? KIND_PAGE : 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 50) w.req_type = REQ_ALLOC;
        else if (pick < 75) w.req_type = REQ_FREE;
        else if (pick < 95) w.req_type = REQ_REF;
        else w.req_type = REQ_BAD;
        pick = $urandom_range(99);
        if (pick < 85) w.run_length = W_RUN'($urandom_range(1, 8));
        else if (pick < 97) w.run_length = W_RUN'($urandom_range(9, 64));
        else w.run_length = W_RUN'($urandom_range(0, 2047));
        return w;
    endfunction

    task automatic random_phase(int n, int idle, int stall, bit m, bit pause);
        write_mode(m);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            // hold the sender until every pending result is back
            if (pause && i == n / 2) drain();
            send_word(random_word(), 1'b0, '0);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (checking && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: %h", o_out_data);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_data.result_status == ST_EVICT) evictions++;
                if (o_out_data.result_status == ST_FAIL) failures++;
                if (o_out_data.result_status !== e.result_status) begin
                    $error("result_status exp %0d got %0d", e.result_status,
                           o_out_data.result_status);
                    errors++;
                end
                if (o_out_data.first_frame !== e.first_frame) begin
                    $error("first_frame exp %0d got %0d", e.first_frame, o_out_data.first_frame);
                    errors++;
                end
                if (o_out_data.evicted_owner !== e.evicted_owner) begin
                    $error("evicted_owner exp %0d got %0d", e.evicted_owner,
                           o_out_data.evicted_owner);
                    errors++;
                end
                if (o_out_data.evicted_page !== e.evicted_page) begin
                    $error("evicted_page exp %h got %h", e.evicted_page, o_out_data.evicted_page);
                    errors++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("timeout, %0d results still pending", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    typedef struct {
        t_in_item  w;
        bit        typed;
        t_out_item res;
    } t_row;

    t_row rows[$];

    function automatic t_row mk(logic [1:0] req, int len, logic [1:0] kind, int owner,
                                int page, int target, bit typed, logic [1:0] st,
                                int first, int ev_owner, int ev_page);
        t_row r;
        r.w = '{req, W_RUN'(len), kind, W_OWNER'(owner), W_PAGE'(page), 10'(target)};
        r.typed = typed;
        r.res = '{st, W_FIRST'(first), W_OWNER'(ev_owner), W_PAGE'(ev_page)};
        return r;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        errors = 0;
        words_sent = 0;
        evictions = 0;
        failures = 0;
        idle_pct = 0;
        stall_pct = 0;
        checking = 1'b0;
        ft_mode = 1'b0;
        ft_head = NIL;
        ft_tail = NIL;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            ft_mapped[f] = 1'b0;
            ft_refd[f] = 1'b0;
            ft_queued[f] = 1'b0;
            ft_age[f] = '0;
            ft_link[f] = NIL;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        checking = 1'b1;

        rows.push_back(mk(REQ_ALLOC, 0, 0, 1, 1, 0, 1, ST_FAIL, 0, 0, 0));
        rows.push_back(mk(REQ_BAD, 5, 0, 1, 1, 7, 1, ST_FAIL, 0, 0, 0));
        rows.push_back(mk(REQ_FREE, 1, 0, 0, 0, 1023, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(REQ_REF, 1, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 2047, 0, 3, 3, 0, 1, ST_FAIL, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 1024, 0, 63, 'hFFFFF, 0, 1, ST_OK, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 1, 1, 0, 0, 0, 1, ST_EVICT, 0, 63, 'hFFFFF));
        rows.push_back(mk(REQ_FREE, 1, 0, 0, 0, 2, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_FREE, 1, 0, 0, 0, 3, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 2, 2, 5, 'h12345, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 3, 0, 9, 'hABCDE, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_REF, 1, 0, 0, 0, 700, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_FREE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_FREE, 1, 0, 0, 0, 1023, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 1, 0, 42, 'h55555, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 1, 3, 21, 'hAAAAA, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_ALLOC, 1024, 0, 7, 'h00001, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_REF, 1, 0, 0, 0, 'h155, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_REF, 1, 0, 0, 0, 'h2AA, 0, 0, 0, 0, 0));

        write_mode(1'b0);
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
        drain();

        random_phase(70, 0, 0, 1'b1, 1'b0);
        random_phase(70, 65, 0, 1'b0, 1'b1);
        random_phase(70, 0, 65, 1'b1, 1'b0);
        random_phase(50, 10, 10, 1'b0, 1'b0);
        random_phase(20, 0, 0, 1'b1, 1'b0);

        $display("%0d request words sent in FIFO and aging mode, %0d evictions, %0d failures",
                 words_sent, evictions, failures);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
